FILE: sv/assert_macros.svh
// Assertion macros used by the checker file isrs_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CHK_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/isrs_pkg.sv
`timescale 1ns / 1ps

package isrs_pkg;

  localparam int MAX_READ_BYTES = 4;
  localparam int CNT_W = $clog2(MAX_READ_BYTES + 1);

  // Event codes on the input channel.
  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_ACK   = 3'd1;
  localparam logic [2:0] OP_NACK  = 3'd2;
  localparam logic [2:0] OP_BYTE  = 3'd3;
  localparam logic [2:0] OP_STOP  = 3'd4;

  // Bus commands on the output channel.
  localparam logic [2:0] BUS_NONE  = 3'd0;
  localparam logic [2:0] BUS_START = 3'd1;
  localparam logic [2:0] BUS_ACK   = 3'd2;
  localparam logic [2:0] BUS_NACK  = 3'd3;
  localparam logic [2:0] BUS_STOP  = 3'd4;

  typedef enum logic [1:0] {
    REG_DEV_ADDR   = 2'd0,
    REG_SENSOR_CMD = 2'd1,
    REG_READ_LEN   = 2'd2
  } reg_index_t;

  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_ADDR_W    = 6'b000010,
    PH_CMD       = 6'b000100,
    PH_ADDR_R    = 6'b001000,
    PH_RECEIVE   = 6'b010000,
    PH_WAIT_STOP = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  bus_command;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        transfer_done;
    logic [31:0] read_value;
    logic        protocol_error;
    logic        last;
  } out_item_t;

  // Results caused by one event: the second is used only when two is set.
  typedef struct packed {
    logic      two;
    out_item_t first;
    out_item_t second;
  } res_pair_t;

endpackage

FILE: sv/isrs_core.sv
`timescale 1ns / 1ps

module isrs_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  isrs_pkg::in_item_t item,
  input  logic [6:0]       device_address,
  input  logic [7:0]       sensor_command,
  input  logic [2:0]       read_length,
  output isrs_pkg::res_pair_t results
);
  import isrs_pkg::*;

  phase_t            phase, phase_next;
  logic              busy, busy_next;
  logic              direction_bit, direction_bit_next;
  logic [CNT_W-1:0]  bytes_received, bytes_received_next;
  logic [31:0]       read_accumulator, read_accumulator_next;

  logic [CNT_W-1:0]  count_inc;
  logic [CNT_W-1:0]  eff_len;
  logic [3:0]        len_ext;
  logic              err;

  // A length of zero reads one byte; larger than the maximum is clamped.
  assign len_ext = {1'b0, read_length};
  always_comb begin
    if (len_ext == 4'd0) begin
      eff_len = CNT_W'(1);
    end else if (len_ext > 4'(MAX_READ_BYTES)) begin
      eff_len = CNT_W'(MAX_READ_BYTES);
    end else begin
      eff_len = CNT_W'(len_ext);
    end
  end

  assign count_inc = bytes_received + CNT_W'(1);

  always_comb begin
    phase_next            = phase;
    busy_next             = busy;
    direction_bit_next    = direction_bit;
    bytes_received_next   = bytes_received;
    read_accumulator_next = read_accumulator;
    results               = '0;
    results.first.last    = 1'b1;
    results.second.last   = 1'b1;
    err                   = 1'b0;

    case (item.operation)
      OP_START: begin
        if (busy) begin
          err = 1'b1;
        end else begin
          busy_next                  = 1'b1;
          phase_next                 = PH_ADDR_W;
          direction_bit_next         = 1'b0;
          bytes_received_next        = '0;
          read_accumulator_next      = '0;
          results.first.bus_command  = BUS_START;
          results.first.tx_valid     = 1'b1;
          results.first.tx_byte      = {device_address, 1'b0};
        end
      end
      OP_ACK: begin
        case (phase)
          PH_ADDR_W: begin
            phase_next               = PH_CMD;
            results.first.tx_valid   = 1'b1;
            results.first.tx_byte    = sensor_command;
          end
          PH_CMD: begin
            phase_next                 = PH_ADDR_R;
            direction_bit_next         = 1'b1;
            results.first.bus_command  = BUS_START;
            results.first.tx_valid     = 1'b1;
            results.first.tx_byte      = {device_address, 1'b1};
          end
          PH_ADDR_R: begin
            phase_next = PH_RECEIVE;
          end
          default: begin
            err = 1'b1;
          end
        endcase
      end
      OP_NACK: begin
        case (phase)
          PH_ADDR_W, PH_ADDR_R: begin
            results.first.bus_command  = BUS_START;
            results.first.tx_valid     = 1'b1;
            results.first.tx_byte      = {device_address, direction_bit};
          end
          PH_CMD: begin
            results.first.tx_valid = 1'b1;
            results.first.tx_byte  = sensor_command;
          end
          default: begin
            err = 1'b1;
          end
        endcase
      end
      OP_BYTE: begin
        if (phase == PH_RECEIVE) begin
          bytes_received_next   = count_inc;
          read_accumulator_next = {read_accumulator[23:0], item.rx_byte};
          if (count_inc >= eff_len) begin
            // Final byte: NACK it, then release the bus.
            phase_next                 = PH_WAIT_STOP;
            results.two                = 1'b1;
            results.first.bus_command  = BUS_NACK;
            results.first.last         = 1'b0;
            results.second.bus_command = BUS_STOP;
          end else begin
            results.first.bus_command = BUS_ACK;
          end
        end else begin
          err = 1'b1;
        end
      end
      OP_STOP: begin
        if (phase == PH_WAIT_STOP) begin
          phase_next                  = PH_IDLE;
          busy_next                   = 1'b0;
          results.first.transfer_done = 1'b1;
          results.first.read_value    = read_accumulator;
        end else begin
          err = 1'b1;
        end
      end
      default: begin
        err = 1'b1;
      end
    endcase

    // An unexpected event reports an error and leaves the state alone.
    if (err) begin
      phase_next                   = phase;
      busy_next                    = busy;
      direction_bit_next           = direction_bit;
      bytes_received_next          = bytes_received;
      read_accumulator_next        = read_accumulator;
      results                      = '0;
      results.first.protocol_error = 1'b1;
      results.first.last           = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      busy             <= 1'b0;
      direction_bit    <= 1'b0;
      bytes_received   <= '0;
      read_accumulator <= '0;
    end else if (fire) begin
      phase            <= phase_next;
      busy             <= busy_next;
      direction_bit    <= direction_bit_next;
      bytes_received   <= bytes_received_next;
      read_accumulator <= read_accumulator_next;
    end
  end

endmodule

FILE: sv/isrs_outq.sv
`timescale 1ns / 1ps

module isrs_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  isrs_pkg::res_pair_t results,
  output logic                can_push,
  output logic                out_valid,
  input  logic                out_stall,
  output isrs_pkg::out_item_t out_data
);
  import isrs_pkg::*;

  logic      pend_valid;
  out_item_t pend_data;
  logic      out_take;
  logic      out_free;

  assign out_take = out_valid & ~out_stall;
  assign out_free = ~out_valid | out_take;
  // A new item needs the output register free and no second result waiting.
  assign can_push = out_free & ~pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (pend_valid && out_free) begin
      out_valid  <= 1'b1;
      out_data   <= pend_data;
      pend_valid <= 1'b0;
    end else if (push) begin
      out_valid  <= 1'b1;
      out_data   <= results.first;
      pend_valid <= results.two;
      pend_data  <= results.second;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: sv/i2c_sensor_read_sequencer.sv
`timescale 1ns / 1ps

// I2C sensor read sequencer: turns bus events into bus commands.
// Input channel (in_valid, in_stall, in_data) carries one event per item:
// start request, ack, nack, received byte or stop done. Output channel
// (out_valid, out_stall, out_data) carries the resulting bus commands,
// bytes to transmit, the finished read value and the error flag; the last
// field marks the final result of an event.
// An accepted item is held in the input register; once the output can take
// it, its first result is registered in the output register. Events that
// cause one result sustain one item per cycle while the output is not
// stalled; the last received byte causes NACK then STOP. The rate is set
// by the single output register plus one holding slot for the second
// result: while that slot is full no new event is processed. A stalled
// output holds its item; in_stall rises once the input register holds an
// item that cannot move on. The APB port sets device address, command and
// read length; writes must be made only while no transfer traffic is in
// flight, which the block does not enforce. Synchronous reset returns the
// sequencer to idle, empties both channels and loads register defaults.
module i2c_sensor_read_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  isrs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output isrs_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import isrs_pkg::*;

  logic       device_valid;
  in_item_t   item;
  logic       can_push;
  logic       fire;
  logic       accept;
  logic       apb_write;
  res_pair_t  results;
  reg_index_t reg_index;

  logic [6:0] device_address;
  logic [7:0] sensor_command;
  logic [2:0] read_length;

  assign fire     = device_valid & can_push;
  assign in_stall = device_valid & ~can_push;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_valid <= 1'b0;
    end else begin
      device_valid <= accept | (device_valid & ~fire);
      if (accept) begin
        item <= in_data;
      end
    end
  end

  assign pready    = 1'b1;
  assign apb_write = psel & penable & pwrite;
  assign reg_index = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 7'd64;
      sensor_command <= 8'd243;
      read_length    <= 3'd2;
    end else if (apb_write) begin
      case (reg_index)
        REG_DEV_ADDR:   device_address <= pwdata[6:0];
        REG_SENSOR_CMD: sensor_command <= pwdata[7:0];
        REG_READ_LEN:   read_length    <= pwdata[2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_DEV_ADDR:   prdata = {25'd0, device_address};
      REG_SENSOR_CMD: prdata = {24'd0, sensor_command};
      REG_READ_LEN:   prdata = {29'd0, read_length};
      default:        prdata = '0;
    endcase
  end

  isrs_core u_core (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .item           (item),
    .device_address (device_address),
    .sensor_command (sensor_command),
    .read_length    (read_length),
    .results        (results)
  );

  isrs_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .results   (results),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: sv/isrs_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module isrs_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input isrs_pkg::out_item_t out_data,
  input logic                pready
);
  import isrs_pkg::*;

  `CHK_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
  `CHK_IMPLY(a_err_clean, clk, rst, out_valid && out_data.protocol_error, out_data.bus_command == BUS_NONE && !out_data.tx_valid && !out_data.transfer_done && out_data.last)
  `CHK_IMPLY(a_nack_before_stop, clk, rst, out_valid && !out_data.last, out_data.bus_command == BUS_NACK && !out_data.protocol_error)
  `CHK_IMPLY(a_done_quiet, clk, rst, out_valid && out_data.transfer_done, out_data.bus_command == BUS_NONE && !out_data.tx_valid && out_data.tx_byte == 8'd0)
  `CHK_IMPLY(a_apb_ready, clk, rst, 1'b1, pready)

endmodule

bind i2c_sensor_read_sequencer isrs_checker u_isrs_checker (.*);
